// File: src/lpfp_pkg.sv
// Package for the length-prefixed frame parser.
// Holds the buffer sizing, queue sizing, command codes, parse modes and the queue word type.
// No dependencies.
package lpfp_pkg;

	// Payload buffer sizing
	localparam int BUFFER_DEPTH = 1024;
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	localparam int LEN_W        = 11;
	localparam int EXP_W        = 16;

	// Queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Command codes
	localparam logic [1:0] CMD_PARSE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// Parse modes, one-hot
	typedef enum logic [6:0] {
		MODE_HUNT_FIRST  = 7'b0000001,
		MODE_HUNT_SECOND = 7'b0000010,
		MODE_LEN_HIGH    = 7'b0000100,
		MODE_LEN_LOW     = 7'b0001000,
		MODE_BODY        = 7'b0010000,
		MODE_CHECK       = 7'b0100000,
		MODE_READY       = 7'b1000000
	} mode_t;

	// One classified word handed from front to back
	typedef struct packed {
		logic              packet_ready;
		logic [LEN_W-1:0]  payload_length;
		logic              wr_en;
		logic              rd_en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} op_t;

endpackage

// File: src/length_prefixed_frame_parser.sv
// Top level of the length-prefixed frame parser.
// Instantiates lpfp_front, lpfp_queue and lpfp_back; depends on lpfp_pkg.
//
//   channel   handshake            payload
//   in        in_valid / in_stall  cmd, data_byte, read_index
//   out       out_valid / out_stall packet_ready, payload_length, read_data
//   config    APB psel/penable     paddr, pwdata, prdata (headers at 0x0, 0x4)
//
// One word per clock sustained while out_stall is low; each word passes the
// queue entry, then the output register with the buffer read, before out_valid
// rises for it. The single-port payload buffer takes one write or one read per
// cycle. Reset (arst_n low) puts the parser in header hunt with count zero;
// buffer contents are not cleared. in_stall rises only when the four-word
// queue is full, which happens only while out_stall holds the output register.
module length_prefixed_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	// APB
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	input  logic [9:0]  read_index,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic        packet_ready,
	output logic [10:0] payload_length,
	output logic [7:0]  read_data
);
	import lpfp_pkg::*;

	op_t  front_op;
	op_t  q_op;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	assign pready   = 1'b1;
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	lpfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.push       (push),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.read_index (read_index),
		.op         (front_op)
	);

	lpfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_op),
		.full   (q_full),
		.pop    (pop),
		.rdata  (q_op),
		.empty  (q_empty)
	);

	lpfp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_op           (q_op),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.packet_ready   (packet_ready),
		.payload_length (payload_length),
		.read_data      (read_data)
	);

endmodule

// File: src/lpfp_front.sv
// Front part of the frame parser: header registers (APB) and the parse state machine.
// Classifies each input word as a buffer write, a buffer read or neither, plus status for the back part.
// Depends on lpfp_pkg.
module lpfp_front (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	// input words
	input  logic                        push,
	input  logic [1:0]                  cmd,
	input  logic [7:0]                  data_byte,
	input  logic [9:0]                  read_index,
	output lpfp_pkg::op_t               op
);
	import lpfp_pkg::*;

	logic [7:0]       header_first_q;
	logic [7:0]       header_second_q;
	mode_t            mode_q, mode_d;
	logic [EXP_W-1:0] exp_q, exp_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;
	logic             cfg_wr;

	// Header registers, byte address 0 and 4
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = paddr[2] ? {24'd0, header_second_q} : {24'd0, header_first_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= 8'd85;
			header_second_q <= 8'd170;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				header_second_q <= pwdata[7:0];
			end else begin
				header_first_q <= pwdata[7:0];
			end
		end
	end

	// Next-state and classification
	always_comb begin
		mode_d   = mode_q;
		exp_d    = exp_q;
		cnt_d    = cnt_q;
		op.wr_en = 1'b0;
		op.rd_en = 1'b0;
		op.addr  = read_index[ADDR_W-1:0];
		op.wdata = data_byte;
		unique case (cmd)
			CMD_PARSE: begin
				unique case (mode_q) inside
					MODE_HUNT_FIRST, MODE_READY: begin
						if (data_byte == header_first_q) begin
							cnt_d  = '0;
							mode_d = MODE_HUNT_SECOND;
						end
					end
					MODE_HUNT_SECOND: begin
						if (data_byte == header_second_q) begin
							mode_d = MODE_LEN_HIGH;
						end else begin
							cnt_d  = '0;
							mode_d = MODE_HUNT_FIRST;
						end
					end
					MODE_LEN_HIGH: begin
						exp_d  = {data_byte, 8'd0};
						mode_d = MODE_LEN_LOW;
					end
					MODE_LEN_LOW: begin
						exp_d  = {exp_q[EXP_W-1:8], data_byte};
						mode_d = MODE_BODY;
						// oversized frame is dropped
						if (32'(exp_d) >= BUFFER_DEPTH) begin
							cnt_d  = '0;
							mode_d = MODE_HUNT_FIRST;
						end
					end
					MODE_BODY: begin
						if (32'(cnt_q) < BUFFER_DEPTH) begin
							op.wr_en = 1'b1;
							op.addr  = cnt_q[ADDR_W-1:0];
							cnt_d    = cnt_q + LEN_W'(1);
						end
						if (EXP_W'(cnt_d) >= exp_q) begin
							mode_d = MODE_CHECK;
						end
					end
					MODE_CHECK: begin
						// trailing check byte is not tested
						mode_d = MODE_READY;
					end
					default: begin
						cnt_d  = '0;
						mode_d = MODE_HUNT_FIRST;
					end
				endcase
			end
			CMD_READ: begin
				op.rd_en = (32'(read_index) < BUFFER_DEPTH);
			end
			CMD_CLEAR: begin
				cnt_d  = '0;
				mode_d = MODE_HUNT_FIRST;
			end
			CMD_NOP: begin
			end
			default: begin
			end
		endcase
		op.packet_ready   = (mode_d == MODE_READY);
		op.payload_length = cnt_d;
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HUNT_FIRST;
			exp_q  <= '0;
			cnt_q  <= '0;
		end else if (push) begin
			mode_q <= mode_d;
			exp_q  <= exp_d;
			cnt_q  <= cnt_d;
		end
	end

	// count never passes the buffer depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= BUFFER_DEPTH)
		else $error("stored count beyond buffer depth");

	// a finished frame holds at least its announced length
	a_ready_len: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_READY || mode_q == MODE_CHECK) |-> (EXP_W'(cnt_q) >= exp_q))
		else $error("frame done with too few payload bytes");

endmodule

// File: src/lpfp_queue.sv
// Short word queue that decouples the parse front from the buffer back.
// Register-based ring with a fill count.
// Depends on lpfp_pkg.
module lpfp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lpfp_pkg::op_t wdata,
	output logic          full,
	input  logic          pop,
	output lpfp_pkg::op_t rdata,
	output logic          empty
);
	import lpfp_pkg::*;

	op_t                mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full  = (32'(cnt_q) == Q_DEPTH);
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == Q_DEPTH - 1) ? '0 : wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == Q_DEPTH - 1) ? '0 : rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");

endmodule

// File: src/lpfp_back.sv
// Back part of the frame parser: payload buffer and the output register.
// Carries out buffer writes and reads in queue order.
// Depends on lpfp_pkg.
module lpfp_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  lpfp_pkg::op_t           q_op,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    packet_ready,
	output logic [10:0]             payload_length,
	output logic [7:0]              read_data
);
	import lpfp_pkg::*;

	logic [7:0]       buf_mem [BUFFER_DEPTH];
	logic [7:0]       rdata_q;
	logic             valid_s1;
	logic             ready_s1;
	logic [LEN_W-1:0] len_s1;
	logic             rd_s1;

	// take a word whenever the output register is free or moving
	assign pop = !q_empty && (!valid_s1 || !out_stall);

	// payload buffer, one write or one read per word
	always_ff @(posedge clk) begin
		if (pop && q_op.wr_en) begin
			buf_mem[q_op.addr] <= q_op.wdata;
		end
		if (pop && q_op.rd_en) begin
			rdata_q <= buf_mem[q_op.addr];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ready_s1 <= q_op.packet_ready;
			len_s1   <= q_op.payload_length;
			rd_s1    <= q_op.rd_en;
		end
	end

	assign out_valid      = valid_s1;
	assign packet_ready   = ready_s1;
	assign payload_length = len_s1;
	assign read_data      = rd_s1 ? rdata_q : 8'd0;

	// a word is either a write or a read, never both
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !(q_op.wr_en && q_op.rd_en))
		else $error("word carries both write and read");

	// a held result is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_stall) |-> !pop)
		else $error("output register overwritten while stalled");

endmodule
